/* rtl/rsenc_pkg.sv */
// Shared types, constants and the GF(256) multiply for the Reed-Solomon evaluation encoder.
package rsenc_pkg;

	localparam int MSG_LEN_W     = 7;
	localparam int CODE_LEN_W    = 9;
	localparam int CFG_INDEX_W   = 1;
	localparam int CFG_DATA_W    = 9;
	localparam int SYMBOL_W      = 8;
	localparam int MAX_MSG_DEFAULT = 64;

	localparam logic [SYMBOL_W:0] GF_POLY = 9'h11B;

	localparam logic [CFG_INDEX_W-1:0] REG_MSG_LEN  = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_CODE_LEN = 1'd1;

	typedef logic [SYMBOL_W-1:0] symbol_t;

	// Shift-and-add multiply, reduced modulo the field polynomial after each shift.
	function automatic symbol_t gf_mul(input symbol_t a, input symbol_t b);
		logic [SYMBOL_W:0] sh;
		symbol_t acc;
		sh  = {1'b0, a};
		acc = '0;
		for (int i = 0; i < SYMBOL_W; i++) begin
			if (b[i]) begin
				acc = acc ^ sh[SYMBOL_W-1:0];
			end
			sh = {sh[SYMBOL_W-1:0], 1'b0};
			if (sh[SYMBOL_W]) begin
				sh = sh ^ GF_POLY;
			end
		end
		return acc;
	endfunction

endpackage

/* rtl/rsenc_in_if.sv */
// Input channel: one load or evaluate item with valid/ready handshake.
interface rsenc_in_if;
	import rsenc_pkg::*;

	logic    valid;
	logic    ready;
	logic    action;
	symbol_t data_byte;

	modport source (output valid, output action, output data_byte, input ready);
	modport sink   (input valid, input action, input data_byte, output ready);
endinterface

/* rtl/rsenc_out_if.sv */
// Output channel: one codeword symbol item with its position and last flag.
interface rsenc_out_if;
	import rsenc_pkg::*;

	logic    valid;
	logic    ready;
	symbol_t codeword_symbol;
	symbol_t position;
	logic    last_symbol;

	modport source (output valid, output codeword_symbol, output position,
		output last_symbol, input ready);
	modport sink   (input valid, input codeword_symbol, input position,
		input last_symbol, output ready);
endinterface

/* rtl/rs_evaluation_encoder_gf256_unit.sv */
// Top level of the Reed-Solomon evaluation encoder over GF(256), polynomial 0x11B.
// Load items store message coefficients lowest degree first; an evaluate item returns the
// message polynomial at the given point together with its codeword position. An evaluate is
// accepted in the idle state; in the run state one GF multiply-add unit is then reused once
// per coefficient of the effective message length, fed from a coefficient memory whose
// registered read runs one step ahead, and the finish state moves the result into the output
// register. The finish state waits as long as the output register still holds a result that
// has not been taken. The block takes no new item while an evaluation is in progress; a
// finished result waits in the output register while the next item is accepted.
module rs_evaluation_encoder_gf256_unit #(
	parameter int MAX_MSG = rsenc_pkg::MAX_MSG_DEFAULT
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [rsenc_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [rsenc_pkg::CFG_DATA_W-1:0]      cfg_data,
	rsenc_in_if.sink                              in_ch,
	rsenc_out_if.source                           out_ch
);
	import rsenc_pkg::*;

	localparam int AW = (MAX_MSG > 1) ? $clog2(MAX_MSG) : 1;
	localparam logic [7:0] MAX_W = 8'(MAX_MSG);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0]              state_q;
	logic [MSG_LEN_W-1:0]    msg_len_q;
	logic [CODE_LEN_W-1:0]   code_len_q;
	logic [MSG_LEN_W-1:0]    loaded_q;
	symbol_t                 pos_q;
	logic [MSG_LEN_W-1:0]    step_q;
	symbol_t                 acc_q;
	symbol_t                 x_q;
	symbol_t                 rd_data_q;
	symbol_t                 mem [MAX_MSG];

	logic                    out_valid_q;
	symbol_t                 out_sym_q;
	symbol_t                 out_pos_q;
	logic                    out_last_q;

	logic [MSG_LEN_W-1:0]    k_eff;
	logic [CODE_LEN_W-1:0]   n_m1;
	logic                    in_fire;
	logic                    do_load;
	logic [AW-1:0]           rd_addr;
	symbol_t                 coef;
	symbol_t                 mac;
	logic                    slot_free;
	logic                    is_last;

	assign k_eff = ({1'b0, msg_len_q} > MAX_W) ? MSG_LEN_W'(MAX_W) : msg_len_q;

	always_comb begin
		if (code_len_q == '0) begin
			n_m1 = '0;
		end else if (code_len_q > CODE_LEN_W'(256)) begin
			n_m1 = CODE_LEN_W'(255);
		end else begin
			n_m1 = code_len_q - CODE_LEN_W'(1);
		end
	end

	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_fire     = in_ch.valid && in_ch.ready;
	assign do_load     = in_fire && !in_ch.action && (loaded_q < k_eff);

	assign rd_addr = (state_q == ST_RUN) ? AW'(step_q - MSG_LEN_W'(1))
		: AW'(k_eff - MSG_LEN_W'(1));
	assign coef    = (step_q < loaded_q) ? rd_data_q : '0;
	assign mac     = gf_mul(acc_q, x_q) ^ coef;

	assign slot_free = !out_valid_q || out_ch.ready;
	assign is_last   = ({1'b0, pos_q} >= n_m1);

	always_ff @(posedge clk) begin
		if (do_load) begin
			mem[AW'(loaded_q)] <= in_ch.data_byte;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msg_len_q  <= MSG_LEN_W'(16);
			code_len_q <= CODE_LEN_W'(255);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MSG_LEN:  msg_len_q  <= cfg_data[MSG_LEN_W-1:0];
				REG_CODE_LEN: code_len_q <= cfg_data[CODE_LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_fire && in_ch.action) begin
					acc_q  <= '0;
					x_q    <= in_ch.data_byte;
					step_q <= k_eff - MSG_LEN_W'(1);
				end
			end
			ST_RUN: begin
				acc_q  <= mac;
				step_q <= step_q - MSG_LEN_W'(1);
			end
			default: ;
		endcase
		if (state_q == ST_FIN && slot_free) begin
			out_sym_q  <= acc_q;
			out_pos_q  <= pos_q;
			out_last_q <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			loaded_q    <= '0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_FIN && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (do_load) begin
						loaded_q <= loaded_q + MSG_LEN_W'(1);
					end
					if (in_fire && in_ch.action) begin
						state_q <= (k_eff == '0) ? ST_FIN : ST_RUN;
					end
				end
				ST_RUN: begin
					if (step_q == '0) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
						if (is_last) begin
							pos_q    <= '0;
							loaded_q <= '0;
						end else begin
							pos_q <= pos_q + 8'd1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_ch.valid           = out_valid_q;
	assign out_ch.codeword_symbol = out_sym_q;
	assign out_ch.position        = out_pos_q;
	assign out_ch.last_symbol     = out_last_q;

endmodule
